// ===== sv/tal_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Tag access list package
// Shared constants, result codes, sequencer steps and the control store.
// ----------------------------------------------------------------------------
package tal_pkg;

    localparam int UID_BYTES_DEF = 4;
    localparam int TAG_SLOTS_DEF = 16;
    localparam int FIRST_SLOT    = 2;
    localparam int UID_PORT_W    = 32;
    localparam int SLOT_OUT_W    = 4;

    typedef enum logic [2:0] {
        OUT_ADMIN_ON  = 3'd0,
        OUT_ADMIN_OFF = 3'd1,
        OUT_REMOVED   = 3'd2,
        OUT_ADDED     = 3'd3,
        OUT_FULL      = 3'd4,
        OUT_GRANTED   = 3'd5,
        OUT_DENIED    = 3'd6
    } t_outcome;

    typedef enum logic [2:0] {
        ST_WAIT   = 3'd0,
        ST_CHECK  = 3'd1,
        ST_PRIME  = 3'd2,
        ST_SCAN   = 3'd3,
        ST_DECIDE = 3'd4,
        ST_TOGGLE = 3'd5
    } t_step;

    typedef enum logic [1:0] {
        C_ALWAYS = 2'd0,
        C_START  = 2'd1,
        C_MASTER = 2'd2,
        C_MORE   = 2'd3
    } t_cond;

    typedef struct packed {
        logic capture;
        logic init_scan;
        logic rd_en;
        logic cmp_en;
        logic decide;
        logic toggle;
    } t_ctrl;

    typedef struct packed {
        t_ctrl ctrl;
        t_cond cond;
        t_step jump;
        t_step next;
    } t_uword;

    typedef struct packed {
        logic master_hit;
        logic scan_more;
    } t_stat;

    function automatic t_uword prog_word(input t_step step);
        t_uword w;
        w = '{ctrl: '0, cond: C_ALWAYS, jump: ST_WAIT, next: ST_WAIT};
        unique case (step)
            ST_WAIT: begin
                w.ctrl.capture = 1'b1;
                w.cond = C_START;
                w.jump = ST_CHECK;
                w.next = ST_WAIT;
            end
            ST_CHECK: begin
                w.ctrl.init_scan = 1'b1;
                w.cond = C_MASTER;
                w.jump = ST_TOGGLE;
                w.next = ST_PRIME;
            end
            ST_PRIME: begin
                w.ctrl.rd_en = 1'b1;
                w.cond = C_MORE;
                w.jump = ST_SCAN;
                w.next = ST_DECIDE;
            end
            ST_SCAN: begin
                w.ctrl.rd_en  = 1'b1;
                w.ctrl.cmp_en = 1'b1;
                w.cond = C_MORE;
                w.jump = ST_SCAN;
                w.next = ST_DECIDE;
            end
            ST_DECIDE: begin
                w.ctrl.decide = 1'b1;
            end
            ST_TOGGLE: begin
                w.ctrl.toggle = 1'b1;
            end
            default: begin
                w.cond = C_ALWAYS;
            end
        endcase
        return w;
    endfunction

endpackage
`default_nettype wire

// ===== sv/tal_seq.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Tag access list sequencer
// Step counter over the control store with conditional jumps.
// ----------------------------------------------------------------------------
module tal_seq (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_start,
    input  wire tal_pkg::t_stat i_stat,
    output tal_pkg::t_ctrl     o_ctrl,
    output logic               o_busy
);

    tal_pkg::t_step  r_step;
    tal_pkg::t_step  n_step;
    tal_pkg::t_uword w_word;
    logic            w_take;

    assign w_word = tal_pkg::prog_word(r_step);

    always_comb begin
        unique case (w_word.cond)
            tal_pkg::C_ALWAYS: w_take = 1'b1;
            tal_pkg::C_START:  w_take = i_start;
            tal_pkg::C_MASTER: w_take = i_stat.master_hit;
            tal_pkg::C_MORE:   w_take = i_stat.scan_more;
            default:           w_take = 1'b1;
        endcase
        n_step = w_take ? w_word.jump : w_word.next;
    end

    always_comb begin
        o_ctrl         = w_word.ctrl;
        o_ctrl.capture = w_word.ctrl.capture & i_start;
        o_busy         = (r_step != tal_pkg::ST_WAIT);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= tal_pkg::ST_WAIT;
        end else begin
            r_step <= n_step;
        end
    end

endmodule
`default_nettype wire

// ===== sv/tal_datapath.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Tag access list datapath
// Slot store, one scan comparator, master comparison, scan bookkeeping and the result register.
// ----------------------------------------------------------------------------
module tal_datapath #(
    parameter int UID_BYTES = tal_pkg::UID_BYTES_DEF,
    parameter int TAG_SLOTS = tal_pkg::TAG_SLOTS_DEF
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire tal_pkg::t_ctrl               i_ctrl,
    input  wire logic [tal_pkg::UID_PORT_W-1:0] i_card_uid,
    input  wire logic                         i_cfg_we,
    input  wire logic [tal_pkg::UID_PORT_W-1:0] i_cfg_wdata,
    output tal_pkg::t_stat                    o_stat,
    output logic                              o_done,
    output logic [2:0]                        o_outcome,
    output logic                              o_admin_active,
    output logic [tal_pkg::SLOT_OUT_W-1:0]    o_slot_used
);

    localparam int UID_W  = (8 * UID_BYTES > tal_pkg::UID_PORT_W) ?
                            tal_pkg::UID_PORT_W : 8 * UID_BYTES;
    localparam int SLOT_W = (TAG_SLOTS > 2) ? $clog2(TAG_SLOTS) : 1;
    localparam int CNT_W  = $clog2(TAG_SLOTS + 1);

    logic [UID_W-1:0]     r_mem [TAG_SLOTS];
    logic [TAG_SLOTS-1:0] r_valid;
    logic [UID_W-1:0]     r_master;
    logic [UID_W-1:0]     r_id;
    logic                 r_admin;
    logic [CNT_W-1:0]     r_rd_slot;
    logic [SLOT_W-1:0]    r_cmp_slot;
    logic [UID_W-1:0]     r_rd_data;
    logic                 r_rd_vld;
    logic                 r_hit_found;
    logic [SLOT_W-1:0]    r_hit_slot;
    logic                 r_emp_found;
    logic [SLOT_W-1:0]    r_emp_slot;
    logic                 r_done;
    tal_pkg::t_outcome    r_outcome;
    logic [tal_pkg::SLOT_OUT_W-1:0] r_slot_out;

    logic w_more;
    logic w_rd;
    logic w_hit;
    logic w_add;
    logic w_remove;

    assign w_more = (r_rd_slot < CNT_W'(TAG_SLOTS));
    assign w_rd   = i_ctrl.rd_en && w_more;
    assign w_hit  = r_rd_vld ? (r_rd_data == r_id) : ((r_id == '0) && r_admin);
    assign w_add    = i_ctrl.decide && r_admin && !r_hit_found && r_emp_found;
    assign w_remove = i_ctrl.decide && r_admin && r_hit_found;

    assign o_stat.master_hit = (r_id == r_master);
    assign o_stat.scan_more  = w_more;

    always_ff @(posedge i_clk) begin
        if (w_add) begin
            r_mem[r_emp_slot] <= r_id;
        end
        if (w_rd) begin
            r_rd_data <= r_mem[r_rd_slot[SLOT_W-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.capture) begin
            r_id <= i_card_uid[UID_W-1:0];
        end
        if (w_rd) begin
            r_rd_vld   <= r_valid[r_rd_slot[SLOT_W-1:0]];
            r_cmp_slot <= r_rd_slot[SLOT_W-1:0];
        end
        if (i_ctrl.cmp_en && !r_hit_found && w_hit) begin
            r_hit_slot <= r_cmp_slot;
        end
        if (i_ctrl.cmp_en && !r_emp_found && !r_rd_vld) begin
            r_emp_slot <= r_cmp_slot;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid     <= '0;
            r_master    <= '0;
            r_admin     <= 1'b0;
            r_rd_slot   <= '0;
            r_hit_found <= 1'b0;
            r_emp_found <= 1'b0;
            r_done      <= 1'b0;
            r_outcome   <= tal_pkg::OUT_DENIED;
            r_slot_out  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_cfg_we) begin
                r_master <= i_cfg_wdata[UID_W-1:0];
            end
            if (i_ctrl.init_scan) begin
                r_rd_slot   <= CNT_W'(tal_pkg::FIRST_SLOT);
                r_hit_found <= 1'b0;
                r_emp_found <= 1'b0;
            end
            if (w_rd) begin
                r_rd_slot <= r_rd_slot + 1'b1;
            end
            if (i_ctrl.cmp_en && w_hit) begin
                r_hit_found <= 1'b1;
            end
            if (i_ctrl.cmp_en && !r_rd_vld) begin
                r_emp_found <= 1'b1;
            end
            if (w_add) begin
                r_valid[r_emp_slot] <= 1'b1;
            end
            if (w_remove) begin
                r_valid[r_hit_slot] <= 1'b0;
            end
            if (i_ctrl.toggle) begin
                r_admin    <= !r_admin;
                r_done     <= 1'b1;
                r_outcome  <= r_admin ? tal_pkg::OUT_ADMIN_OFF : tal_pkg::OUT_ADMIN_ON;
                r_slot_out <= '0;
            end
            if (i_ctrl.decide) begin
                r_done <= 1'b1;
                priority if (r_admin && r_hit_found) begin
                    r_outcome  <= tal_pkg::OUT_REMOVED;
                    r_slot_out <= tal_pkg::SLOT_OUT_W'(r_hit_slot);
                end else if (r_admin && r_emp_found) begin
                    r_outcome  <= tal_pkg::OUT_ADDED;
                    r_slot_out <= tal_pkg::SLOT_OUT_W'(r_emp_slot);
                end else if (r_admin) begin
                    r_outcome  <= tal_pkg::OUT_FULL;
                    r_slot_out <= '0;
                end else if (r_hit_found) begin
                    r_outcome  <= tal_pkg::OUT_GRANTED;
                    r_slot_out <= tal_pkg::SLOT_OUT_W'(r_hit_slot);
                end else begin
                    r_outcome  <= tal_pkg::OUT_DENIED;
                    r_slot_out <= '0;
                end
            end
        end
    end

    assign o_done         = r_done;
    assign o_outcome      = r_outcome;
    assign o_admin_active = r_admin;
    assign o_slot_used    = r_slot_out;

endmodule
`default_nettype wire

// ===== sv/tag_access_list_with_enroll_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Tag access list with enrollment
// A presented tag identifier is checked against a master identifier and a
// table of enrolled tags. Each start transaction gives one result.
//
// Input: a transaction is taken at an edge with start high and busy low;
// i_card_uid is sampled then. Configuration: i_cfg_we writes the master
// identifier from i_cfg_wdata; the user alone must write it only while idle.
// Output: o_done is high for exactly one cycle with o_outcome,
// o_admin_active and o_slot_used valid; the receiver cannot stall it.
// Timing: a master tag passes the check and toggle steps before its result.
// Any other tag passes the check and prime steps, a scan of slots FIRST_SLOT
// to TAG_SLOTS - 1 at one slot a cycle through the single store read port
// and scan comparator, and the decide step. Busy drops in the cycle o_done is
// shown, so a new tag may be started then.
// Reset: empties every slot, clears the master identifier and returns to
// normal mode; the block is ready in the first cycle after reset.
// ----------------------------------------------------------------------------
module tag_access_list_with_enroll_core #(
    parameter int UID_BYTES = tal_pkg::UID_BYTES_DEF,
    parameter int TAG_SLOTS = tal_pkg::TAG_SLOTS_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [31:0] i_card_uid,
    input  wire logic        i_cfg_we,
    input  wire logic [31:0] i_cfg_wdata,
    output logic             o_done,
    output logic [2:0]       o_outcome,
    output logic             o_admin_active,
    output logic [3:0]       o_slot_used
);

    tal_pkg::t_ctrl w_ctrl;
    tal_pkg::t_stat w_stat;

    tal_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_stat  (w_stat),
        .o_ctrl  (w_ctrl),
        .o_busy  (busy)
    );

    tal_datapath #(
        .UID_BYTES (UID_BYTES),
        .TAG_SLOTS (TAG_SLOTS)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_ctrl         (w_ctrl),
        .i_card_uid     (i_card_uid),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata),
        .o_stat         (w_stat),
        .o_done         (o_done),
        .o_outcome      (o_outcome),
        .o_admin_active (o_admin_active),
        .o_slot_used    (o_slot_used)
    );

endmodule
`default_nettype wire

// ===== sv/tal_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Tag access list checker
// Port-level properties of the block, attached to the top level by bind.
// ----------------------------------------------------------------------------
module tal_checker (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       start,
    input wire logic       busy,
    input wire logic       o_done,
    input wire logic [2:0] o_outcome,
    input wire logic       o_admin_active,
    input wire logic [3:0] o_slot_used
);

    // Every accepted transaction keeps the block busy in the next cycle.
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accepted transaction did not raise busy");

    // Leaving the busy state always delivers a result.
    a_fall_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($fell(busy) && $past(i_rst_n)) |-> o_done)
        else $error("busy fell without a result");

    // A result is never shown while the block stays idle.
    a_done_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && $past(i_rst_n)) |-> $past(busy))
        else $error("result without a transaction in progress");

    // Mode toggles report the new mode and no slot.
    a_toggle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && (o_outcome == tal_pkg::OUT_ADMIN_ON ||
                    o_outcome == tal_pkg::OUT_ADMIN_OFF))
        |-> (o_slot_used == '0 &&
             o_admin_active == (o_outcome == tal_pkg::OUT_ADMIN_ON)))
        else $error("mode toggle result inconsistent");

    // Grants and denials only occur in normal mode.
    a_normal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && (o_outcome == tal_pkg::OUT_GRANTED ||
                    o_outcome == tal_pkg::OUT_DENIED)) |-> !o_admin_active)
        else $error("access decision reported in admin mode");

endmodule

bind tag_access_list_with_enroll_core tal_checker u_tal_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .start          (start),
    .busy           (busy),
    .o_done         (o_done),
    .o_outcome      (o_outcome),
    .o_admin_active (o_admin_active),
    .o_slot_used    (o_slot_used)
);
`default_nettype wire

// ===== tb/sv/tal_access_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tag access list checker
// Watches the start, configuration and result channels of the tag access
// list, keeps its own copy of the tag table, mode and master identifier,
// predicts the verdict of every accepted transaction and compares each
// strobed result with the oldest pending verdict.
// ----------------------------------------------------------------------------
module tal_access_checker #(
    parameter int SLOTS = tal_pkg::TAG_SLOTS_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_start,
    input  wire logic        i_busy,
    input  wire logic [31:0] i_card_uid,
    input  wire logic        i_cfg_we,
    input  wire logic [31:0] i_cfg_wdata,
    input  wire logic        i_done,
    input  wire logic [2:0]  i_outcome,
    input  wire logic        i_admin_active,
    input  wire logic [3:0]  i_slot_used,
    output int               o_errors,
    output int               o_pending,
    output int               o_checked
);

    localparam logic [31:0] UID_MASK = (tal_pkg::UID_BYTES_DEF >= 4) ? 32'hFFFF_FFFF :
        32'((64'd1 << (8 * tal_pkg::UID_BYTES_DEF)) - 1);

    typedef struct packed {
        tal_pkg::t_outcome outcome;
        logic              admin;
        logic [3:0]        slot;
    } t_verdict;

    logic [31:0] tag_table [SLOTS];
    logic        admin_on;
    logic [31:0] master_id;
    t_verdict    pending_verdicts[$];
    int          fail_count  = 0;
    int          match_count = 0;

    assign o_errors  = fail_count;
    assign o_checked = match_count;

    task automatic judge_tag(input logic [31:0] uid, output t_verdict v);
        logic [31:0] id;
        logic [31:0] held;
        bit          found;
        id = uid & UID_MASK;
        found = 1'b0;
        v.slot = '0;
        if (id == (master_id & UID_MASK)) begin
            admin_on = !admin_on;
            v.outcome = admin_on ? tal_pkg::OUT_ADMIN_ON : tal_pkg::OUT_ADMIN_OFF;
        end else if (admin_on) begin
            for (int s = tal_pkg::FIRST_SLOT; s < SLOTS && !found; s++) begin
                if ((tag_table[s] & UID_MASK) == id) begin
                    tag_table[s] = '0;
                    v.outcome = tal_pkg::OUT_REMOVED;
                    v.slot = 4'(s);
                    found = 1'b1;
                end
            end
            for (int s = tal_pkg::FIRST_SLOT; s < SLOTS && !found; s++) begin
                if ((tag_table[s] & UID_MASK) == '0) begin
                    tag_table[s] = id;
                    v.outcome = tal_pkg::OUT_ADDED;
                    v.slot = 4'(s);
                    found = 1'b1;
                end
            end
            if (!found) begin
                v.outcome = tal_pkg::OUT_FULL;
            end
        end else begin
            v.outcome = tal_pkg::OUT_DENIED;
            for (int s = tal_pkg::FIRST_SLOT; s < SLOTS && !found; s++) begin
                held = tag_table[s] & UID_MASK;
                if (held != '0 && held == id) begin
                    v.outcome = tal_pkg::OUT_GRANTED;
                    v.slot = 4'(s);
                    found = 1'b1;
                end
            end
        end
        v.admin = admin_on;
    endtask

    always @(posedge i_clk) begin : watch
        t_verdict want;
        t_verdict fresh;
        if (!i_rst_n) begin
            for (int s = 0; s < SLOTS; s++) begin
                tag_table[s] = '0;
            end
            admin_on = 1'b0;
            master_id = '0;
            pending_verdicts.delete();
            o_pending <= 0;
        end else begin
            if (i_done) begin
                if (pending_verdicts.size() == 0) begin
                    $error("Result with no transaction pending: outcome %0d slot %0d",
                           i_outcome, i_slot_used);
                    fail_count++;
                end else begin
                    want = pending_verdicts.pop_front();
                    match_count++;
                    if (i_outcome !== want.outcome) begin
                        $error("outcome mismatch: expected %0d, actual %0d",
                               want.outcome, i_outcome);
                        fail_count++;
                    end
                    if (i_admin_active !== want.admin) begin
                        $error("admin_active mismatch: expected %0d, actual %0d",
                               want.admin, i_admin_active);
                        fail_count++;
                    end
                    if (i_slot_used !== want.slot) begin
                        $error("slot_used mismatch: expected %0d, actual %0d",
                               want.slot, i_slot_used);
                        fail_count++;
                    end
                end
            end
            if (i_cfg_we) begin
                master_id = i_cfg_wdata;
            end
            if (i_start && !i_busy) begin
                judge_tag(i_card_uid, fresh);
                pending_verdicts.push_back(fresh);
            end
            o_pending <= pending_verdicts.size();
        end
    end

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tag access list testbench
// Drives directed and random tag transactions in bursts with random gaps,
// rewrites the master identifier between phases while the block is idle,
// and reports the verdict from the failure and pending counts of the checker.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int POOL_SIZE = 20;
    localparam int PHASES    = 5;
    localparam int PER_PHASE = 400;

    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        start       = 1'b0;
    logic [31:0] i_card_uid  = '0;
    logic        i_cfg_we    = 1'b0;
    logic [31:0] i_cfg_wdata = '0;
    logic        busy;
    logic        o_done;
    logic [2:0]  o_outcome;
    logic        o_admin_active;
    logic [3:0]  o_slot_used;

    int errors;
    int pending;
    int checked;
    int sent   = 0;
    int writes = 0;

    logic [31:0] master_now = '0;
    logic [31:0] tag_pool [POOL_SIZE];

    always #6 i_clk = ~i_clk;

    tag_access_list_with_enroll_core uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_card_uid     (i_card_uid),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata),
        .o_done         (o_done),
        .o_outcome      (o_outcome),
        .o_admin_active (o_admin_active),
        .o_slot_used    (o_slot_used)
    );

    tal_access_checker u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_start        (start),
        .i_busy         (busy),
        .i_card_uid     (i_card_uid),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_done         (o_done),
        .i_outcome      (o_outcome),
        .i_admin_active (o_admin_active),
        .i_slot_used    (o_slot_used),
        .o_errors       (errors),
        .o_pending      (pending),
        .o_checked      (checked)
    );

    task automatic present_tag(input logic [31:0] uid);
        start <= 1'b1;
        i_card_uid <= uid;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        sent++;
    endtask

    task automatic hold_off(input int cycles);
        start <= 1'b0;
        repeat (cycles) @(posedge i_clk);
    endtask

    task automatic drain;
        hold_off(2);
        while (pending != 0 || busy) @(posedge i_clk);
    endtask

    task automatic set_master(input logic [31:0] value);
        drain();
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= value;
        master_now = value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        writes++;
    endtask

    function automatic logic [31:0] pick_tag;
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 8) return master_now;
        if (roll < 11) return 32'h0;
        if (roll < 28) return $urandom;
        return tag_pool[$urandom_range(0, POOL_SIZE - 1)];
    endfunction

    initial begin
        #20_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    initial begin : stimulus
        logic [31:0] next_master;
        int          left;
        int          burst;
        int          roll;

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Master identifier still at its reset value of zero.
        present_tag(32'h0000_0000);
        present_tag(32'h0000_0000);
        present_tag(32'h1234_5678);

        set_master(32'hFFFF_FFFF);
        present_tag(32'hFFFF_FFFF);
        present_tag(32'h0000_0000);
        present_tag(32'h0000_0001);
        present_tag(32'h8000_0000);
        present_tag(32'h0000_0001);
        present_tag(32'hA5A5_A5A5);
        for (int k = 0; k < 12; k++) begin
            present_tag(32'h0100_0000 + k);
        end
        present_tag(32'h5A5A_5A5A);
        present_tag(32'h0000_0000);
        present_tag(32'hFFFF_FFFF);
        present_tag(32'h8000_0000);
        present_tag(32'h0000_0000);

        for (int k = 0; k < POOL_SIZE; k++) begin
            tag_pool[k] = $urandom;
        end

        for (int ph = 0; ph < PHASES; ph++) begin
            case (ph)
                0: next_master = $urandom;
                1: next_master = 32'h0000_0000;
                2: next_master = 32'hFFFF_FFFF;
                3: next_master = tag_pool[0];
                default: next_master = $urandom;
            endcase
            set_master(next_master);
            if (ph != 3) begin
                for (int k = 0; k < POOL_SIZE; k++) begin
                    tag_pool[k] = $urandom;
                end
            end
            left = PER_PHASE;
            while (left > 0) begin
                burst = $urandom_range(1, 12);
                for (int k = 0; k < burst && left > 0; k++) begin
                    present_tag(pick_tag());
                    left--;
                end
                roll = $urandom_range(0, 49);
                if (roll == 0) begin
                    drain();
                end else if (roll > 14) begin
                    hold_off($urandom_range(1, 30));
                end
            end
        end

        drain();
        repeat (25) @(posedge i_clk);

        $display("Sent %0d tag transactions under %0d master settings, %0d results checked.",
                 sent, writes + 1, checked);
        if (errors + pending == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
sv/tal_pkg.sv
sv/tal_seq.sv
sv/tal_datapath.sv
sv/tag_access_list_with_enroll_core.sv
sv/tal_checker.sv
tb/sv/tal_access_checker.sv
tb/sv/tb_top.sv
